>>> hdl/tjd_pkg.sv
// ----------------------------------------------------------------------------
// Touch joystick package
// Shared widths, state encoding and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package tjd_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 4;

	localparam int TOUCH_W  = 12;
	localparam int BOX_W    = 12;
	localparam int DZ_W     = 15;
	localparam int GAIN_W   = 7;
	localparam int VEL_W    = 16;

	localparam int SMOOTH_W = COORD_BITS + FRAC_BITS;
	localparam int SPAN_W   = DZ_W + 1;
	localparam int TOP_W    = DZ_W + 2;
	localparam int PROD_W   = SMOOTH_W + TOP_W;
	localparam int DIVR_W   = BOX_W + FRAC_BITS;
	localparam int V_W      = TOP_W + 1;
	localparam int P_W      = V_W + GAIN_W + 1;
	localparam int GAIN_SHIFT = GAIN_W;

	localparam int DIV_STEPS = PROD_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam int COORD_MAX = (1 << COORD_BITS) - 1;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_BOX_LEFT   = 3'd0;
	localparam logic [2:0] REG_BOX_TOP    = 3'd1;
	localparam logic [2:0] REG_BOX_WIDTH  = 3'd2;
	localparam logic [2:0] REG_BOX_HEIGHT = 3'd3;
	localparam logic [2:0] REG_DEAD_ZONE  = 3'd4;
	localparam logic [2:0] REG_SPEED_GAIN = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_DIV,
		ST_NORM,
		ST_GAIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic div_load;
		logic div_step;
		logic norm;
		logic gain;
		logic out_load;
		logic out_zero;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic out_free;
	} sts_t;

endpackage

>>> hdl/tjd_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned long division, one quotient bit per step, quotient shifted into
// the dividend register.
// ----------------------------------------------------------------------------
module tjd_div (
	input  logic                              clk,
	input  logic                              load,
	input  logic                              step,
	input  logic [tjd_pkg::PROD_W-1:0]        dividend,
	input  logic [tjd_pkg::DIVR_W-1:0]        divisor,
	output logic [tjd_pkg::PROD_W-1:0]        quotient
);

	logic [tjd_pkg::PROD_W-1:0] dvd_q;
	logic [tjd_pkg::DIVR_W-1:0] rem_q;
	logic [tjd_pkg::DIVR_W:0]   shifted;
	logic [tjd_pkg::DIVR_W:0]   diff;
	logic                       ge;

	assign shifted = {rem_q, dvd_q[tjd_pkg::PROD_W-1]};
	assign diff    = shifted - {1'b0, divisor};
	assign ge      = shifted >= {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (step) begin
			dvd_q <= {dvd_q[tjd_pkg::PROD_W-2:0], ge};
			rem_q <= ge ? diff[tjd_pkg::DIVR_W-1:0] : shifted[tjd_pkg::DIVR_W-1:0];
		end
	end

	assign quotient = dvd_q;

endmodule

>>> hdl/tjd_ctrl.sv
// ----------------------------------------------------------------------------
// Touch joystick controller
// Sequences one touch sample through evaluation, division and scaling.
// ----------------------------------------------------------------------------
module tjd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  tjd_pkg::sts_t sts,
	output tjd_pkg::cmd_t cmd
);

	tjd_pkg::state_t state_q, state_d;
	logic [tjd_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic zero_q, zero_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tjd_pkg::ST_IDLE;
			cnt_q   <= '0;
			zero_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			zero_q  <= zero_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		zero_d   = zero_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			tjd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = tjd_pkg::ST_EVAL;
				end
			end
			tjd_pkg::ST_EVAL: begin
				cmd.eval = 1'b1;
				zero_d   = !sts.hit;
				state_d  = sts.hit ? tjd_pkg::ST_MUL : tjd_pkg::ST_OUT;
			end
			tjd_pkg::ST_MUL: begin
				cmd.div_load = 1'b1;
				cnt_d        = '0;
				state_d      = tjd_pkg::ST_DIV;
			end
			tjd_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == tjd_pkg::CNT_W'(tjd_pkg::DIV_STEPS - 1)) begin
					state_d = tjd_pkg::ST_NORM;
				end
			end
			tjd_pkg::ST_NORM: begin
				cmd.norm = 1'b1;
				state_d  = tjd_pkg::ST_GAIN;
			end
			tjd_pkg::ST_GAIN: begin
				cmd.gain = 1'b1;
				state_d  = tjd_pkg::ST_OUT;
			end
			tjd_pkg::ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_zero = zero_q;
					state_d      = tjd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tjd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/tjd_dp.sv
// ----------------------------------------------------------------------------
// Touch joystick datapath
// Drag state, smoothing, mapping by division, dead zone, gain and the
// output register.
// ----------------------------------------------------------------------------
module tjd_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tjd_pkg::cmd_t                cmd,
	output tjd_pkg::sts_t                sts,
	input  logic [tjd_pkg::BOX_W-1:0]    box_left,
	input  logic [tjd_pkg::BOX_W-1:0]    box_top,
	input  logic [tjd_pkg::BOX_W-1:0]    box_width,
	input  logic [tjd_pkg::BOX_W-1:0]    box_height,
	input  logic [tjd_pkg::DZ_W-1:0]     dead_zone,
	input  logic [tjd_pkg::GAIN_W-1:0]   speed_gain,
	input  logic [23:0]                  s_tdata,
	input  logic                         s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata,
	output logic                         m_tuser
);

	localparam int SW = tjd_pkg::SMOOTH_W;

	logic                        touch_q;
	logic [tjd_pkg::TOUCH_W-1:0] pos_q [2];
	logic                        drag_q;
	logic [SW-1:0]               smooth_q [2];

	logic [tjd_pkg::BOX_W-1:0]   lo [2];
	logic [tjd_pkg::BOX_W-1:0]   size [2];
	logic [tjd_pkg::BOX_W:0]     hi [2];
	logic [tjd_pkg::TOUCH_W-1:0] off [2];
	logic [SW-1:0]               tgt [2];
	logic [SW-1:0]               seed [2];
	logic [SW:0]                 sum [2];
	logic                        in_box;

	logic [tjd_pkg::SPAN_W-1:0]  span;
	logic [tjd_pkg::TOP_W-1:0]   top;
	logic [tjd_pkg::DIVR_W-1:0]  divisor [2];
	logic [tjd_pkg::PROD_W-1:0]  product [2];
	logic [tjd_pkg::PROD_W-1:0]  quot [2];
	logic [tjd_pkg::TOP_W-1:0]   qc [2];
	logic signed [tjd_pkg::V_W-1:0] v [2];
	logic signed [tjd_pkg::V_W-1:0] vd [2];
	logic signed [tjd_pkg::V_W-1:0] dz_s;
	logic signed [tjd_pkg::V_W-1:0] vd_q [2];
	logic signed [tjd_pkg::P_W-1:0] p_q [2];
	logic signed [tjd_pkg::P_W-1:0] r [2];
	logic [tjd_pkg::VEL_W-1:0]   vel [2];

	localparam logic signed [tjd_pkg::P_W-1:0] VEL_MAX = tjd_pkg::P_W'(32767);
	localparam logic signed [tjd_pkg::P_W-1:0] VEL_MIN = -tjd_pkg::P_W'(32768);

	assign lo[0]   = box_left;
	assign lo[1]   = box_top;
	assign size[0] = box_width;
	assign size[1] = box_height;

	assign span = tjd_pkg::SPAN_W'(1 << tjd_pkg::DZ_W) + tjd_pkg::SPAN_W'(dead_zone);
	assign top  = {span, 1'b0};
	assign dz_s = $signed(tjd_pkg::V_W'(dead_zone));

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			hi[i] = {1'b0, lo[i]} + {1'b0, size[i]};
			if (pos_q[i] <= lo[i]) begin
				off[i] = '0;
			end else begin
				off[i] = pos_q[i] - lo[i];
				if (off[i] > size[i]) begin
					off[i] = size[i];
				end
				if (int'(off[i]) > tjd_pkg::COORD_MAX) begin
					off[i] = tjd_pkg::TOUCH_W'(tjd_pkg::COORD_MAX);
				end
			end
			tgt[i]  = SW'(32'(off[i]) << tjd_pkg::FRAC_BITS);
			seed[i] = drag_q ? smooth_q[i] : tgt[i];
			sum[i]  = {1'b0, seed[i]} + {1'b0, tgt[i]};

			divisor[i] = {(size[i] == '0) ? tjd_pkg::BOX_W'(1) : size[i],
				tjd_pkg::FRAC_BITS'(0)};
			product[i] = tjd_pkg::PROD_W'(smooth_q[i]) * tjd_pkg::PROD_W'(top);

			qc[i] = (quot[i] > tjd_pkg::PROD_W'(top)) ? top : quot[i][tjd_pkg::TOP_W-1:0];
			v[i]  = $signed({1'b0, qc[i]}) - $signed(tjd_pkg::V_W'(span));
			if (v[i] > dz_s) begin
				vd[i] = v[i] - dz_s;
			end else if (v[i] > -dz_s) begin
				vd[i] = '0;
			end else begin
				vd[i] = v[i] + dz_s;
			end

			r[i] = p_q[i] >>> tjd_pkg::GAIN_SHIFT;
			if (r[i] > VEL_MAX) begin
				vel[i] = tjd_pkg::VEL_W'(VEL_MAX);
			end else if (r[i] < VEL_MIN) begin
				vel[i] = tjd_pkg::VEL_W'(VEL_MIN);
			end else begin
				vel[i] = r[i][tjd_pkg::VEL_W-1:0];
			end
		end
	end

	assign in_box = (pos_q[0] >= lo[0]) && ({1'b0, pos_q[0]} <= hi[0]) &&
		(pos_q[1] >= lo[1]) && ({1'b0, pos_q[1]} <= hi[1]);

	assign sts.hit      = touch_q && (drag_q || in_box);
	assign sts.out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_q      <= 1'b0;
			smooth_q[0] <= '0;
			smooth_q[1] <= '0;
			m_tvalid    <= 1'b0;
		end else begin
			if (cmd.eval) begin
				if (!touch_q) begin
					drag_q <= 1'b0;
				end else if (sts.hit) begin
					drag_q      <= 1'b1;
					smooth_q[0] <= sum[0][SW:1];
					smooth_q[1] <= sum[1][SW:1];
				end
			end
			if (cmd.out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			touch_q  <= s_tuser;
			pos_q[0] <= s_tdata[11:0];
			pos_q[1] <= s_tdata[23:12];
		end
		for (int i = 0; i < 2; i++) begin
			if (cmd.norm) begin
				vd_q[i] <= vd[i];
			end
			if (cmd.gain) begin
				p_q[i] <= tjd_pkg::P_W'(vd_q[i]) * $signed({1'b0, speed_gain});
			end
		end
		if (cmd.out_load) begin
			m_tdata <= cmd.out_zero ? '0 : {vel[1], vel[0]};
			m_tuser <= !cmd.out_zero;
		end
	end

	for (genvar g = 0; g < 2; g++) begin : g_div
		tjd_div u_div (
			.clk      (clk),
			.load     (cmd.div_load),
			.step     (cmd.div_step),
			.dividend (product[g]),
			.divisor  (divisor[g]),
			.quotient (quot[g])
		);
	end

endmodule

>>> hdl/touch_joystick_deadzone.sv
// A sample with a touch in the box passes the 33-step restoring
// divider; a release or a missed touch goes straight to the output.
// No new sample is taken until the last result is loaded for output.
// The output register lets the next sample enter while a result waits.
// Reset: asynchronous, active low; clears the drag state, the smoothed
// position and the output valid, and loads the register defaults.
// ----------------------------------------------------------------------------
// Touch joystick with dead zone
// Turns touch samples into saturated Q1.15 velocities through a smoothed,
// box-relative position, a dead zone and a gain.
// ----------------------------------------------------------------------------
module touch_joystick_deadzone (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tjd_pkg::ADDR_W-1:0]   paddr,
	input  logic [tjd_pkg::DATA_W-1:0]   pwdata,
	output logic [tjd_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [23:0]                  s_tdata,  // touch_x, touch_y
	input  logic                         s_tuser,  // touch_valid
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata,  // vel_x, vel_y
	output logic                         m_tuser   // tracking
);

	logic [tjd_pkg::BOX_W-1:0]  box_left_q, box_top_q, box_width_q, box_height_q;
	logic [tjd_pkg::DZ_W-1:0]   dead_zone_q;
	logic [tjd_pkg::GAIN_W-1:0] speed_gain_q;
	logic [2:0]                 reg_idx;
	logic                       wr_en;
	tjd_pkg::cmd_t              cmd;
	tjd_pkg::sts_t              sts;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_left_q   <= '0;
			box_top_q    <= '0;
			box_width_q  <= tjd_pkg::BOX_W'(256);
			box_height_q <= tjd_pkg::BOX_W'(256);
			dead_zone_q  <= tjd_pkg::DZ_W'(3277);
			speed_gain_q <= tjd_pkg::GAIN_W'(4);
		end else if (wr_en) begin
			case (reg_idx)
				tjd_pkg::REG_BOX_LEFT:   box_left_q   <= pwdata[tjd_pkg::BOX_W-1:0];
				tjd_pkg::REG_BOX_TOP:    box_top_q    <= pwdata[tjd_pkg::BOX_W-1:0];
				tjd_pkg::REG_BOX_WIDTH:  box_width_q  <= pwdata[tjd_pkg::BOX_W-1:0];
				tjd_pkg::REG_BOX_HEIGHT: box_height_q <= pwdata[tjd_pkg::BOX_W-1:0];
				tjd_pkg::REG_DEAD_ZONE:  dead_zone_q  <= pwdata[tjd_pkg::DZ_W-1:0];
				tjd_pkg::REG_SPEED_GAIN: speed_gain_q <= pwdata[tjd_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tjd_pkg::REG_BOX_LEFT:   prdata = tjd_pkg::DATA_W'(box_left_q);
			tjd_pkg::REG_BOX_TOP:    prdata = tjd_pkg::DATA_W'(box_top_q);
			tjd_pkg::REG_BOX_WIDTH:  prdata = tjd_pkg::DATA_W'(box_width_q);
			tjd_pkg::REG_BOX_HEIGHT: prdata = tjd_pkg::DATA_W'(box_height_q);
			tjd_pkg::REG_DEAD_ZONE:  prdata = tjd_pkg::DATA_W'(dead_zone_q);
			tjd_pkg::REG_SPEED_GAIN: prdata = tjd_pkg::DATA_W'(speed_gain_q);
			default:                 prdata = '0;
		endcase
	end

	tjd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tjd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.box_left   (box_left_q),
		.box_top    (box_top_q),
		.box_width  (box_width_q),
		.box_height (box_height_q),
		.dead_zone  (dead_zone_q),
		.speed_gain (speed_gain_q),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

	// A result without tracking carries zero velocities.
	a_zero_vel: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("idle result with nonzero velocity");

	// Once a sample is taken, no other is taken until its result is loaded.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("sample accepted while busy");

	// A new result only appears at the end of a sample's processing.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result without a sample in flight");

endmodule
